### sv/fri_pkg.sv
// Shared types and constants for the fragment reorder and reassembly block.
package fri_pkg;

  localparam int ID_W        = 20;
  localparam int SRC_W       = 8;
  localparam int PAY_W       = 64;
  localparam int NB_W        = 4;
  localparam int BT_W        = 32;
  localparam int CFG_W       = 20;
  localparam int DEF_WINDOW  = 16;
  localparam int DEF_QDEPTH  = 4;

  localparam logic [NB_W-1:0] NB_MAX = NB_W'(8);

  typedef enum logic [0:0] {
    CFG_TOTAL  = 1'b0,
    CFG_SOURCE = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    OP_FRAGMENT = 1'b0,
    OP_OTHER    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_STORED    = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_COMPLETE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD
  } back_state_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  payload;
    logic [NB_W-1:0]   nbytes;
    logic              completed;
    logic [BT_W-1:0]   byte_total;
  } job_t;

endpackage

### sv/fri_if.sv
// Valid/ready channel interfaces for fragment input items and result items.
interface fri_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [fri_pkg::SRC_W-1:0]  source_id;
  logic [fri_pkg::ID_W-1:0]   fragment_id;
  logic [fri_pkg::PAY_W-1:0]  payload;
  logic [fri_pkg::NB_W-1:0]   payload_bytes;

  modport source (output valid, op, source_id, fragment_id, payload, payload_bytes,
                  input ready);
  modport sink   (input valid, op, source_id, fragment_id, payload, payload_bytes,
                  output ready);
endinterface

interface fri_out_if;
  logic                       valid;
  logic                       ready;
  logic                       has_data;
  logic [fri_pkg::ID_W-1:0]   out_index;
  logic [fri_pkg::PAY_W-1:0]  out_payload;
  logic [fri_pkg::NB_W-1:0]   out_bytes;
  logic [2:0]                 status;
  logic                       completed;
  logic [fri_pkg::BT_W-1:0]   bytes_received;
  logic                       last;

  modport source (output valid, has_data, out_index, out_payload, out_bytes, status,
                  completed, bytes_received, last, input ready);
  modport sink   (input valid, has_data, out_index, out_payload, out_bytes, status,
                  completed, bytes_received, last, output ready);
endinterface

### sv/fri_queue.sv
// Short first-in first-out queue of jobs between the front and back parts.
module fri_queue #(
  parameter int W     = 8,
  parameter int DEPTH = fri_pkg::DEF_QDEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         wr_ready,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         rd_valid
);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_push  = push && wr_ready;
  assign do_pop   = pop && rd_valid;
  assign dout     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

### sv/fri_front.sv
// Front part: accepts and classifies fragments, keeps window state, issues jobs.
module fri_front #(
  parameter int WINDOW = fri_pkg::DEF_WINDOW,
  localparam int SLOT_W = $clog2(WINDOW)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [fri_pkg::CFG_W-1:0]   cfg_wdata,
  fri_in_if.sink                      in_if,
  output logic                        job_push,
  output fri_pkg::job_t               job,
  output logic [SLOT_W-1:0]           job_slot,
  output logic [SLOT_W-1:0]           job_drain,
  input  logic                        q_ready
);

  localparam int ID_W = fri_pkg::ID_W;
  localparam int BT_W = fri_pkg::BT_W;

  logic [ID_W-1:0]          total_r;
  logic [fri_pkg::SRC_W-1:0] source_r;
  logic [ID_W-1:0]          ne_r, ne_nxt;
  logic [SLOT_W-1:0]        head_r, head_nxt;
  logic [BT_W-1:0]          bt_r, bt_nxt;
  logic                     done_r, done_nxt;
  logic [WINDOW-1:0]        valid_r, valid_nxt;

  logic                     accept;
  logic [fri_pkg::NB_W-1:0] nb_sat;
  logic                     done_now, ignored, in_win;
  logic [ID_W-1:0]          id_gap;
  logic [SLOT_W:0]          slot_sum, head_sum;
  logic [SLOT_W-1:0]        slot_s, head_nx1, run;
  logic [2*WINDOW-1:0]      dbl_valid, dbl_clr;
  logic [WINDOW-1:0]        rot_valid, thermo, clr;
  logic [BT_W:0]            bt_sum;
  logic [BT_W-1:0]          bt_add;
  logic [ID_W-1:0]          ne_deliver;

  assign in_if.ready = q_ready;
  assign accept      = in_if.valid && q_ready;

  always_comb begin
    nb_sat   = (in_if.payload_bytes > fri_pkg::NB_MAX) ? fri_pkg::NB_MAX
                                                        : in_if.payload_bytes;
    done_now = done_r || (ne_r == total_r);
    ignored  = (in_if.op != fri_pkg::OP_FRAGMENT) || (in_if.source_id != source_r);
    id_gap   = in_if.fragment_id - ne_r;
    in_win   = (id_gap < ID_W'(WINDOW));

    slot_sum = {1'b0, head_r} + id_gap[SLOT_W:0];
    slot_s   = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
               SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : slot_sum[SLOT_W-1:0];
    head_nx1 = (head_r == SLOT_W'(WINDOW - 1)) ? '0 : head_r + SLOT_W'(1);

    dbl_valid = {valid_r, valid_r} >> head_nx1;
    rot_valid = dbl_valid[WINDOW-1:0];
    run = SLOT_W'(WINDOW - 1);
    for (int k = WINDOW - 1; k >= 0; k--) begin
      if (!rot_valid[k]) run = SLOT_W'(k);
    end
    thermo  = (WINDOW'(1) << run) - WINDOW'(1);
    dbl_clr = {thermo, thermo} << head_nx1;
    clr     = dbl_clr[2*WINDOW-1:WINDOW];

    head_sum   = {1'b0, head_nx1} + {1'b0, run};
    ne_deliver = ne_r + ID_W'(1) + ID_W'(run);

    bt_sum = {1'b0, bt_r} + (BT_W+1)'(nb_sat);
    bt_add = bt_sum[BT_W] ? '1 : bt_sum[BT_W-1:0];
  end

  always_comb begin
    ne_nxt    = ne_r;
    head_nxt  = head_r;
    bt_nxt    = bt_r;
    done_nxt  = done_r;
    valid_nxt = valid_r;

    job.status     = fri_pkg::ST_COMPLETE;
    job.id         = in_if.fragment_id;
    job.payload    = in_if.payload;
    job.nbytes     = nb_sat;
    job.completed  = 1'b0;
    job.byte_total = bt_r;
    job_slot       = slot_s;
    job_drain      = '0;

    priority if (done_now) begin
      job.status    = fri_pkg::ST_COMPLETE;
      job.id        = '0;
      job.completed = 1'b1;
      done_nxt      = 1'b1;
    end else if (ignored) begin
      job.status = fri_pkg::ST_IGNORED;
      job.id     = '0;
    end else if (id_gap == '0) begin
      job.status     = fri_pkg::ST_DELIVERED;
      job.byte_total = bt_add;
      job.completed  = (ne_deliver == total_r);
      job_slot       = head_nx1;
      job_drain      = run;
      bt_nxt         = bt_add;
      ne_nxt         = ne_deliver;
      head_nxt       = (head_sum >= (SLOT_W+1)'(WINDOW)) ?
                       SLOT_W'(head_sum - (SLOT_W+1)'(WINDOW)) : head_sum[SLOT_W-1:0];
      valid_nxt      = valid_r & ~clr;
      done_nxt       = (ne_deliver == total_r);
    end else if (in_win && valid_r[slot_s]) begin
      job.status = fri_pkg::ST_DUPLICATE;
    end else if (in_win) begin
      job.status        = fri_pkg::ST_STORED;
      job.byte_total    = bt_add;
      bt_nxt            = bt_add;
      valid_nxt[slot_s] = 1'b1;
    end else begin
      job.status = fri_pkg::ST_OUTSIDE;
    end
  end

  assign job_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      source_r <= '0;
    end else if (cfg_we) begin
      unique case (fri_pkg::cfg_idx_t'(cfg_index))
        fri_pkg::CFG_TOTAL:  total_r  <= cfg_wdata[ID_W-1:0];
        fri_pkg::CFG_SOURCE: source_r <= cfg_wdata[fri_pkg::SRC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r    <= '0;
      head_r  <= '0;
      bt_r    <= '0;
      done_r  <= 1'b0;
      valid_r <= '0;
    end else if (accept) begin
      ne_r    <= ne_nxt;
      head_r  <= head_nxt;
      bt_r    <= bt_nxt;
      done_r  <= done_nxt;
      valid_r <= valid_nxt;
    end
  end

  a_head_free: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[head_r])
    else $error("slot of next expected fragment is marked stored");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("completion flag dropped");

endmodule

### sv/fri_back.sv
// Back part: emits results, writes stored fragments and drains successors.
module fri_back #(
  parameter int WINDOW = fri_pkg::DEF_WINDOW,
  localparam int SLOT_W = $clog2(WINDOW)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  fri_pkg::job_t        job,
  input  logic [SLOT_W-1:0]    job_slot,
  input  logic [SLOT_W-1:0]    job_drain,
  output logic                 q_pop,
  fri_out_if.source            out_if
);

  localparam int ID_W  = fri_pkg::ID_W;
  localparam int PAY_W = fri_pkg::PAY_W;
  localparam int NB_W  = fri_pkg::NB_W;
  localparam int BT_W  = fri_pkg::BT_W;

  logic [PAY_W-1:0] mem_pay [WINDOW];
  logic [NB_W-1:0]  mem_nb  [WINDOW];
  logic [PAY_W-1:0] rd_pay_r;
  logic [NB_W-1:0]  rd_nb_r;
  logic             mem_we;

  fri_pkg::back_state_t state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] addr_r, addr_nxt;
  logic [ID_W-1:0]   idx_r, idx_nxt;
  logic              cmp_r, cmp_nxt;
  logic [BT_W-1:0]   bt_r, bt_nxt;

  logic              ov_r, ov_nxt;
  logic              has_r, has_nxt;
  logic [ID_W-1:0]   oidx_r, oidx_nxt;
  logic [PAY_W-1:0]  opay_r, opay_nxt;
  logic [NB_W-1:0]   onb_r, onb_nxt;
  logic [2:0]        ost_r, ost_nxt;
  logic              ocmp_r, ocmp_nxt;
  logic [BT_W-1:0]   obt_r, obt_nxt;
  logic              olast_r, olast_nxt;
  logic              out_free, job_has;

  assign out_free = !ov_r || out_if.ready;
  assign job_has  = (job.status == fri_pkg::ST_DELIVERED);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    idx_nxt   = idx_r;
    cmp_nxt   = cmp_r;
    bt_nxt    = bt_r;
    ov_nxt    = ov_r && !out_if.ready;
    has_nxt   = has_r;
    oidx_nxt  = oidx_r;
    opay_nxt  = opay_r;
    onb_nxt   = onb_r;
    ost_nxt   = ost_r;
    ocmp_nxt  = ocmp_r;
    obt_nxt   = obt_r;
    olast_nxt = olast_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;

    unique case (state_r)
      fri_pkg::BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop     = 1'b1;
          mem_we    = (job.status == fri_pkg::ST_STORED);
          ov_nxt    = 1'b1;
          has_nxt   = job_has;
          oidx_nxt  = job.id;
          opay_nxt  = job_has ? job.payload : '0;
          onb_nxt   = job_has ? job.nbytes : '0;
          ost_nxt   = job.status;
          ocmp_nxt  = job.completed;
          obt_nxt   = job.byte_total;
          olast_nxt = (job_drain == '0);
          if (job_drain != '0) begin
            state_nxt = fri_pkg::BK_READ;
            addr_nxt  = job_slot;
            cnt_nxt   = job_drain;
            idx_nxt   = job.id + ID_W'(1);
            cmp_nxt   = job.completed;
            bt_nxt    = job.byte_total;
          end
        end
      end
      fri_pkg::BK_READ: begin
        state_nxt = fri_pkg::BK_LOAD;
      end
      fri_pkg::BK_LOAD: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          has_nxt   = 1'b1;
          oidx_nxt  = idx_r;
          opay_nxt  = rd_pay_r;
          onb_nxt   = rd_nb_r;
          ost_nxt   = fri_pkg::ST_DELIVERED;
          ocmp_nxt  = cmp_r;
          obt_nxt   = bt_r;
          olast_nxt = (cnt_r == SLOT_W'(1));
          addr_nxt  = (addr_r == SLOT_W'(WINDOW - 1)) ? '0 : addr_r + SLOT_W'(1);
          idx_nxt   = idx_r + ID_W'(1);
          cnt_nxt   = cnt_r - SLOT_W'(1);
          state_nxt = (cnt_r == SLOT_W'(1)) ? fri_pkg::BK_IDLE : fri_pkg::BK_READ;
        end
      end
      default: begin
        state_nxt = fri_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fri_pkg::BK_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    idx_r   <= idx_nxt;
    cmp_r   <= cmp_nxt;
    bt_r    <= bt_nxt;
    has_r   <= has_nxt;
    oidx_r  <= oidx_nxt;
    opay_r  <= opay_nxt;
    onb_r   <= onb_nxt;
    ost_r   <= ost_nxt;
    ocmp_r  <= ocmp_nxt;
    obt_r   <= obt_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_pay[job_slot] <= job.payload;
      mem_nb[job_slot]  <= job.nbytes;
    end
    rd_pay_r <= mem_pay[addr_r];
    rd_nb_r  <= mem_nb[addr_r];
  end

  assign out_if.valid          = ov_r;
  assign out_if.has_data       = has_r;
  assign out_if.out_index      = oidx_r;
  assign out_if.out_payload    = opay_r;
  assign out_if.out_bytes      = onb_r;
  assign out_if.status         = ost_r;
  assign out_if.completed      = ocmp_r;
  assign out_if.bytes_received = obt_r;
  assign out_if.last           = olast_r;

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != fri_pkg::BK_IDLE) |-> (cnt_r != '0))
    else $error("drain active with no fragments left");

endmodule

### sv/fragment_reorder_reassembly.sv
// Top level of the fragment reorder and reassembly block.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------------
//  in_if    | in        | valid/ready       | op, source_id, fragment_id, payload, bytes
//  out_if   | out       | valid/ready       | has_data, out_index, ..., last
//  cfg_*    | in        | cfg_we, no stall  | cfg_index, cfg_wdata
//
//  An input item is classified in the cycle it is accepted; one is taken per cycle
//  while the job queue (QDEPTH entries) has room.
//  For each item the back part loads its first result into the output register, then
//  drains each stored successor by a slot memory read, then an output register load.
//  Reset is synchronous; there is no clearing pass.
//  A stalled result holds in the output register; the queue then fills and
//  in_if.ready drops.
module fragment_reorder_reassembly #(
  parameter int WINDOW = fri_pkg::DEF_WINDOW,
  parameter int QDEPTH = fri_pkg::DEF_QDEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [fri_pkg::CFG_W-1:0]  cfg_wdata,
  fri_in_if.sink                     in_if,
  fri_out_if.source                  out_if
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int JOB_W  = $bits(fri_pkg::job_t);
  localparam int QW     = JOB_W + 2 * SLOT_W;

  fri_pkg::job_t     f_job, b_job;
  logic [SLOT_W-1:0] f_slot, f_drain, b_slot, b_drain;
  logic              f_push, q_ready, q_valid, q_pop;
  logic [QW-1:0]     q_din, q_dout;

  assign q_din = {f_job, f_slot, f_drain};
  assign {b_job, b_slot, b_drain} = q_dout;

  fri_front #(.WINDOW(WINDOW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .job_push  (f_push),
    .job       (f_job),
    .job_slot  (f_slot),
    .job_drain (f_drain),
    .q_ready   (q_ready)
  );

  fri_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .din      (q_din),
    .wr_ready (q_ready),
    .pop      (q_pop),
    .dout     (q_dout),
    .rd_valid (q_valid)
  );

  fri_back #(.WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .job       (b_job),
    .job_slot  (b_slot),
    .job_drain (b_drain),
    .q_pop     (q_pop),
    .out_if    (out_if)
  );

endmodule
